// File: rtl/core/wrtc_pkg.sv
package wrtc_pkg;

  // Geometry of the sample history.
  localparam int RING_DEPTH  = 6;
  localparam int NUM_SOURCES = 2;
  localparam int SRC_W       = 1;
  localparam int IDX_W       = $clog2(RING_DEPTH);
  localparam int CNT_W       = $clog2(RING_DEPTH + 1);
  localparam int EXT_W       = CNT_W + 1;
  localparam int MEM_DEPTH   = NUM_SOURCES * RING_DEPTH;
  localparam int ADDR_W      = $clog2(MEM_DEPTH);

  // Field widths.
  localparam int TIME_W  = 32;
  localparam int PCT_W   = 15;
  localparam int RATE_W  = 16;
  localparam int TIER_W  = 2;
  localparam int ENTRY_W = TIME_W + PCT_W;

  // 60000 ms per minute, times 4 to line up Q.10 rates with Q7.8 percent.
  localparam int MS_PER_MIN_X4 = 240000;
  localparam int SCALE_W       = 18;
  localparam int LHS_W         = PCT_W + SCALE_W;
  localparam int RHS_W         = RATE_W + TIME_W;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIER1_RATE    = 3'd0,
    CFG_TIER2_RATE    = 3'd1,
    CFG_TIER3_RATE    = 3'd2,
    CFG_SPAN_FLOOR_MS = 3'd3,
    CFG_RESTART_DROP  = 3'd4
  } cfg_reg_t;

  typedef enum logic [TIER_W-1:0] {
    TIER_IDLE   = 2'd0,
    TIER_NORMAL = 2'd1,
    TIER_ACTIVE = 2'd2,
    TIER_HEAVY  = 2'd3
  } tier_t;

  typedef struct packed {
    logic [RATE_W-1:0] tier1_rate;
    logic [RATE_W-1:0] tier2_rate;
    logic [RATE_W-1:0] tier3_rate;
    logic [TIME_W-1:0] span_floor_ms;
  } tier_cfg_t;

  // Span of one source's history after the new sample went in.
  typedef struct packed {
    logic [SRC_W-1:0]  src;
    logic [TIME_W-1:0] dt;
    logic [PCT_W-1:0]  dp;
    logic              enough;
    logic              restarted;
  } span_rec_t;

  function automatic logic [ADDR_W-1:0] ring_addr(logic [SRC_W-1:0] src,
                                                  logic [IDX_W-1:0] idx);
    return ADDR_W'(ADDR_W'(src) * ADDR_W'(RING_DEPTH) + ADDR_W'(idx));
  endfunction

endpackage

// File: rtl/core/wrtc_ring_ram.sv
module wrtc_ring_ram #(
  parameter int DATA_W = 47,
  parameter int DEPTH  = 12,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [DATA_W-1:0] rdata_a,
  output logic [DATA_W-1:0] rdata_b
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rd_a_r;
  logic [DATA_W-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Write-first: a read of the entry being written returns the new data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r <= (we && (waddr == raddr_a)) ? wdata : mem_r[raddr_a];
      rd_b_r <= (we && (waddr == raddr_b)) ? wdata : mem_r[raddr_b];
    end
  end

  assign rdata_a = rd_a_r;
  assign rdata_b = rd_b_r;

endmodule

// File: rtl/core/wrtc_hist_ctrl.sv
module wrtc_hist_ctrl
  import wrtc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [SRC_W-1:0]  in_source,
  input  logic [TIME_W-1:0] in_timestamp_ms,
  input  logic [PCT_W-1:0]  in_usage_pct,
  input  logic [PCT_W-1:0]  restart_drop,
  input  logic              span_ready,
  output logic              span_valid,
  output span_rec_t         span
);

  logic [CNT_W-1:0]  fill_r   [NUM_SOURCES];
  logic [CNT_W-1:0]  fill_nxt [NUM_SOURCES];
  logic [IDX_W-1:0]  wp_r     [NUM_SOURCES];
  logic [IDX_W-1:0]  wp_nxt   [NUM_SOURCES];

  logic              a_valid_r;
  logic [SRC_W-1:0]  a_src_r;
  logic [TIME_W-1:0] a_time_r;
  logic [PCT_W-1:0]  a_pct_r;
  logic [CNT_W-1:0]  a_fill_r;
  logic [IDX_W-1:0]  a_wp_r;

  logic              accept;
  logic              fire_a;
  logic              restart;
  logic [IDX_W-1:0]  wpos;
  logic [IDX_W-1:0]  wp_upd;
  logic [CNT_W-1:0]  fill_upd;
  logic [PCT_W-1:0]  latest_pct;
  logic [TIME_W-1:0] old_time;
  logic [PCT_W-1:0]  old_pct;

  logic [CNT_W-1:0]  eff_fill;
  logic [IDX_W-1:0]  eff_wp;
  logic [CNT_W-1:0]  next_fill;
  logic [IDX_W-1:0]  next_wp;
  logic [EXT_W-1:0]  wp_ext;
  logic [EXT_W-1:0]  fill_ext;
  logic [EXT_W-1:0]  oldest_ext;
  logic [IDX_W-1:0]  latest_idx;
  logic [IDX_W-1:0]  first_idx;

  logic [ENTRY_W-1:0] rd_latest;
  logic [ENTRY_W-1:0] rd_oldest;

  assign in_stall   = a_valid_r && !span_ready;
  assign accept     = in_valid && !in_stall;
  assign fire_a     = a_valid_r && span_ready;
  assign span_valid = a_valid_r;

  // Stage A: restart decision, write slot and the span to the oldest sample.
  always_comb begin
    latest_pct = rd_latest[PCT_W-1:0];
    old_time   = rd_oldest[ENTRY_W-1:PCT_W];
    old_pct    = rd_oldest[PCT_W-1:0];
    restart    = (a_fill_r != '0) &&
                 (({1'b0, a_pct_r} + {1'b0, restart_drop}) < {1'b0, latest_pct});
    wpos       = restart ? '0 : a_wp_r;
    wp_upd     = (wpos == IDX_W'(RING_DEPTH - 1)) ? '0 : wpos + 1'b1;
    if (restart) begin
      fill_upd = CNT_W'(1);
    end else if (a_fill_r == CNT_W'(RING_DEPTH)) begin
      fill_upd = a_fill_r;
    end else begin
      fill_upd = a_fill_r + 1'b1;
    end
    span.src       = a_src_r;
    span.dt        = a_time_r - old_time;
    span.dp        = (a_pct_r > old_pct) ? a_pct_r - old_pct : '0;
    span.enough    = fill_upd >= CNT_W'(2);
    span.restarted = restart;
  end

  // Per-source counters including the word that leaves stage A this cycle,
  // so a word of the same source can follow directly.
  always_comb begin
    for (int i = 0; i < NUM_SOURCES; i++) begin
      fill_nxt[i] = fill_r[i];
      wp_nxt[i]   = wp_r[i];
      if (fire_a && (a_src_r == SRC_W'(i))) begin
        fill_nxt[i] = fill_upd;
        wp_nxt[i]   = wp_upd;
      end
    end
  end

  // Read addresses for the incoming word. The oldest slot assumes no restart;
  // after a restart the span is too short to matter.
  always_comb begin
    eff_fill   = fill_nxt[in_source];
    eff_wp     = wp_nxt[in_source];
    latest_idx = (eff_wp == '0) ? IDX_W'(RING_DEPTH - 1) : eff_wp - 1'b1;
    next_fill  = (eff_fill == CNT_W'(RING_DEPTH)) ? eff_fill : eff_fill + 1'b1;
    next_wp    = (eff_wp == IDX_W'(RING_DEPTH - 1)) ? '0 : eff_wp + 1'b1;
    wp_ext     = EXT_W'(next_wp);
    fill_ext   = EXT_W'(next_fill);
    if (wp_ext >= fill_ext) begin
      oldest_ext = wp_ext - fill_ext;
    end else begin
      oldest_ext = wp_ext + EXT_W'(RING_DEPTH) - fill_ext;
    end
    first_idx = oldest_ext[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      for (int i = 0; i < NUM_SOURCES; i++) begin
        fill_r[i] <= '0;
        wp_r[i]   <= '0;
      end
    end else begin
      if (!in_stall) begin
        a_valid_r <= in_valid;
      end
      for (int i = 0; i < NUM_SOURCES; i++) begin
        fill_r[i] <= fill_nxt[i];
        wp_r[i]   <= wp_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_src_r  <= in_source;
      a_time_r <= in_timestamp_ms;
      a_pct_r  <= in_usage_pct;
      a_fill_r <= eff_fill;
      a_wp_r   <= eff_wp;
    end
  end

  wrtc_ring_ram #(
    .DATA_W (ENTRY_W),
    .DEPTH  (MEM_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ring_ram (
    .clk     (clk),
    .we      (fire_a),
    .waddr   (ring_addr(a_src_r, wpos)),
    .wdata   ({a_time_r, a_pct_r}),
    .rd_en   (accept),
    .raddr_a (ring_addr(in_source, latest_idx)),
    .raddr_b (ring_addr(in_source, first_idx)),
    .rdata_a (rd_latest),
    .rdata_b (rd_oldest)
  );

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r |-> (a_fill_r <= CNT_W'(RING_DEPTH)))
    else $error("fill count above ring depth");

  a_wp_tracks_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && (a_fill_r < CNT_W'(RING_DEPTH))) |-> (a_wp_r == IDX_W'(a_fill_r)))
    else $error("write position out of step with fill count");

  a_restart_short: assert property (@(posedge clk) disable iff (!rst_n)
    (span_valid && span.restarted) |-> !span.enough)
    else $error("restarted history reported as long enough");
`endif

endmodule

// File: rtl/core/wrtc_tier_calc.sv
module wrtc_tier_calc
  import wrtc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              span_valid,
  input  span_rec_t         span,
  output logic              span_ready,
  input  tier_cfg_t         cfg,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SRC_W-1:0]  out_source_out,
  output logic [TIER_W-1:0] out_rate_tier,
  output logic              out_restarted
);

  logic              b_valid_r;
  logic [SRC_W-1:0]  b_src_r;
  logic              b_restarted_r;
  logic              b_ok_r;
  logic [TIME_W-1:0] b_dt_r;
  logic [PCT_W-1:0]  b_dp_r;

  logic              c_valid_r;
  logic [SRC_W-1:0]  c_src_r;
  logic              c_restarted_r;
  logic              c_ok_r;
  logic [LHS_W-1:0]  c_lhs_r;
  logic [RHS_W-1:0]  c_rhs1_r;
  logic [RHS_W-1:0]  c_rhs2_r;
  logic [RHS_W-1:0]  c_rhs3_r;

  logic              out_valid_r;
  logic [SRC_W-1:0]  out_src_r;
  tier_t             out_tier_r;
  logic              out_restarted_r;

  logic              en_out;
  logic              en_c;
  logic              en_b;
  logic [RHS_W-1:0]  lhs_ext;
  tier_t             tier;

  assign en_out     = !out_valid_r || !out_stall;
  assign en_c       = !c_valid_r || en_out;
  assign en_b       = !b_valid_r || en_c;
  assign span_ready = en_b;

  // Thresholds are tested in order; the first one the rate is below wins.
  always_comb begin
    lhs_ext = RHS_W'(c_lhs_r);
    if (!c_ok_r) begin
      tier = TIER_IDLE;
    end else if (lhs_ext < c_rhs1_r) begin
      tier = TIER_IDLE;
    end else if (lhs_ext < c_rhs2_r) begin
      tier = TIER_NORMAL;
    end else if (lhs_ext < c_rhs3_r) begin
      tier = TIER_ACTIVE;
    end else begin
      tier = TIER_HEAVY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en_b) begin
        b_valid_r <= span_valid;
      end
      if (en_c) begin
        c_valid_r <= b_valid_r;
      end
      if (en_out) begin
        out_valid_r <= c_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_b && span_valid) begin
      b_src_r       <= span.src;
      b_restarted_r <= span.restarted;
      b_ok_r        <= span.enough && (span.dt >= cfg.span_floor_ms);
      b_dt_r        <= span.dt;
      b_dp_r        <= span.dp;
    end
    if (en_c && b_valid_r) begin
      c_src_r       <= b_src_r;
      c_restarted_r <= b_restarted_r;
      c_ok_r        <= b_ok_r;
      c_lhs_r       <= LHS_W'(b_dp_r) * LHS_W'(MS_PER_MIN_X4);
      c_rhs1_r      <= RHS_W'(cfg.tier1_rate) * RHS_W'(b_dt_r);
      c_rhs2_r      <= RHS_W'(cfg.tier2_rate) * RHS_W'(b_dt_r);
      c_rhs3_r      <= RHS_W'(cfg.tier3_rate) * RHS_W'(b_dt_r);
    end
    if (en_out && c_valid_r) begin
      out_src_r       <= c_src_r;
      out_tier_r      <= tier;
      out_restarted_r <= c_restarted_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_source_out = out_src_r;
  assign out_rate_tier  = out_tier_r;
  assign out_restarted  = out_restarted_r;

`ifndef SYNTH
  a_restart_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_restarted) |-> (out_rate_tier == TIER_IDLE))
    else $error("restarted source reported a nonzero tier");
`endif

endmodule

// File: rtl/core/windowed_rate_tier_classifier_core.sv
// Channel  | Direction | Handshake             | Payload
// ---------+-----------+-----------------------+--------------------------------------------
// in       | input     | in_valid / in_stall   | in_source, in_timestamp_ms, in_usage_pct
// out      | output    | out_valid / out_stall | out_source_out, out_rate_tier, out_restarted
// cfg      | input     | cfg_we                | cfg_index, cfg_wdata
//
// One word is taken every clock cycle while in_stall is low, also when consecutive words hit
// the same source. Stage A loads together with the history read, then the span stage, the
// multiply stage and the output register follow. The rate is set by the history RAM, which
// does one read-modify-write per word, with a write-first bypass for back-to-back words.
// Reset is synchronous and active low; it clears the per-source fill counts and write
// positions and loads the register defaults. The history RAM needs no clearing pass.
// A stalled output lets the pipeline fill up; in_stall rises only once every stage holds
// a word.
module windowed_rate_tier_classifier_core
  import wrtc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [SRC_W-1:0]      in_source,
  input  logic [TIME_W-1:0]     in_timestamp_ms,
  input  logic [PCT_W-1:0]      in_usage_pct,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [SRC_W-1:0]      out_source_out,
  output logic [TIER_W-1:0]     out_rate_tier,
  output logic                  out_restarted,

  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers. Rates are in %/min with ten fraction bits; the
  // defaults are roughly 0.10, 0.20 and 0.33 %/min. The restart drop is in
  // Q7.8 percent and defaults to 5.0 %.
  logic [RATE_W-1:0] tier1_rate_r;
  logic [RATE_W-1:0] tier2_rate_r;
  logic [RATE_W-1:0] tier3_rate_r;
  logic [TIME_W-1:0] span_floor_ms_r;
  logic [PCT_W-1:0]  restart_drop_r;

  tier_cfg_t         tier_cfg;
  logic              span_valid;
  logic              span_ready;
  span_rec_t         span;

  // Writes to indexes beyond the register list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tier1_rate_r    <= RATE_W'(102);
      tier2_rate_r    <= RATE_W'(205);
      tier3_rate_r    <= RATE_W'(338);
      span_floor_ms_r <= TIME_W'(240000);
      restart_drop_r  <= PCT_W'(1280);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_TIER1_RATE:    tier1_rate_r    <= cfg_wdata[RATE_W-1:0];
        CFG_TIER2_RATE:    tier2_rate_r    <= cfg_wdata[RATE_W-1:0];
        CFG_TIER3_RATE:    tier3_rate_r    <= cfg_wdata[RATE_W-1:0];
        CFG_SPAN_FLOOR_MS: span_floor_ms_r <= cfg_wdata[TIME_W-1:0];
        CFG_RESTART_DROP:  restart_drop_r  <= cfg_wdata[PCT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign tier_cfg.tier1_rate    = tier1_rate_r;
  assign tier_cfg.tier2_rate    = tier2_rate_r;
  assign tier_cfg.tier3_rate    = tier3_rate_r;
  assign tier_cfg.span_floor_ms = span_floor_ms_r;

  // History side: per-source ring in RAM, restart detection and the span
  // between the newest and the oldest sample.
  wrtc_hist_ctrl u_hist_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_source       (in_source),
    .in_timestamp_ms (in_timestamp_ms),
    .in_usage_pct    (in_usage_pct),
    .restart_drop    (restart_drop_r),
    .span_ready      (span_ready),
    .span_valid      (span_valid),
    .span            (span)
  );

  // Rate side: the division is replaced by dp * 240000 against thr * dt,
  // with the products registered before the compares.
  wrtc_tier_calc u_tier_calc (
    .clk            (clk),
    .rst_n          (rst_n),
    .span_valid     (span_valid),
    .span           (span),
    .span_ready     (span_ready),
    .cfg            (tier_cfg),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_source_out (out_source_out),
    .out_rate_tier  (out_rate_tier),
    .out_restarted  (out_restarted)
  );

endmodule
